FILE: sv/mes_pkg.sv
// ----------------------------------------------------------------------------
// mes_pkg: shared types, constants and helpers for the event scorer
// Holds transaction structs, state encoding, rounding helpers and the sigmoid table.
// ----------------------------------------------------------------------------
package mes_pkg;

  localparam int FEATURES_DEF = 4;
  localparam int HIDDEN_DEF   = 8;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SCORE = 1'b1;

  typedef struct packed {
    logic               command;
    logic [5:0]         coeff_index;
    logic signed [23:0] coeff_value;
    logic signed [23:0] feature_a;
    logic signed [23:0] feature_b;
    logic signed [23:0] feature_c;
    logic signed [23:0] feature_d;
  } in_t;

  typedef struct packed {
    logic signed [23:0] logit;
    logic [15:0]        score;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_HID,
    ST_OUT,
    ST_SIG,
    ST_DONE
  } state_t;

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sh7fffff;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic logic signed [23:0] to_q12(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + 64'sd2048) >>> 12;
    return sat24(t);
  endfunction

  function automatic logic [16:0] sig_tab(input logic [4:0] k);
    logic [16:0] r;
    case (k)
      5'd0:  r = 17'd32768;
      5'd1:  r = 17'd40793;
      5'd2:  r = 17'd47911;
      5'd3:  r = 17'd53581;
      5'd4:  r = 17'd57724;
      5'd5:  r = 17'd60565;
      5'd6:  r = 17'd62428;
      5'd7:  r = 17'd63615;
      5'd8:  r = 17'd64357;
      5'd9:  r = 17'd64816;
      5'd10: r = 17'd65097;
      5'd11: r = 17'd65269;
      5'd12: r = 17'd65374;
      5'd13: r = 17'd65438;
      5'd14: r = 17'd65476;
      5'd15: r = 17'd65500;
      default: r = 17'd65514;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/mlp_event_scorer_unit.sv
// ----------------------------------------------------------------------------
// mlp_event_scorer_unit: 4-8-1 perceptron event scorer
// Coefficient registers, hidden lanes in parallel, merge and sigmoid.
// ----------------------------------------------------------------------------
// channel | direction | payload
// in      | input     | mes_pkg::in_t (load or score transaction)
// out     | output    | mes_pkg::out_t (logit, score)
// A load leaves the block idle. A score holds the block until its result is
// taken past any output stalls: three steps per feature to normalize (mean,
// inverse sd, product), one lane step per feature, HIDDEN merge steps, the
// sigmoid step and the result step; the next transaction is taken once the
// block is back in idle.
// Reset clears control only; the coefficients are undefined until loaded.
// in_stall is high while a score is in flight or a result waits.
module mlp_event_scorer_unit #(
  parameter int FEATURES = mes_pkg::FEATURES_DEF,
  parameter int HIDDEN   = mes_pkg::HIDDEN_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  mes_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output mes_pkg::out_t  out_data
);

  localparam int OFS_B2 = 2 * FEATURES + FEATURES * HIDDEN + 2 * HIDDEN;
  localparam int FW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int HW = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;

  logic signed [23:0] feat [4];
  logic signed [23:0] raw [FEATURES];
  logic signed [23:0] mean_c [FEATURES];
  logic signed [23:0] isd_c [FEATURES];
  logic signed [23:0] bias2;
  logic signed [23:0] xr [FEATURES];
  logic signed [23:0] hv [HIDDEN];
  logic signed [23:0] w2v [HIDDEN];
  logic signed [23:0] logit;

  mes_pkg::state_t state, state_next;
  logic [FW-1:0] fi;
  logic [HW-1:0] hi;
  logic [1:0] ph;
  logic signed [23:0] mean_r, isd_r;
  logic signed [28:0] diff;
  logic signed [52:0] nprod;
  logic start, lstep, mstep, accept, load;
  logic signed [23:0] lg;
  logic [15:0] a;
  logic [16:0] lo, hi_t, pos;
  logic signed [18:0] dl;
  logic signed [30:0] ip;

  assign accept = in_valid && !in_stall;
  assign load = accept && in_data.command == mes_pkg::CMD_LOAD;
  assign in_stall = (state != mes_pkg::ST_IDLE);
  assign out_valid = (state == mes_pkg::ST_DONE);

  assign feat[0] = in_data.feature_a;
  assign feat[1] = in_data.feature_b;
  assign feat[2] = in_data.feature_c;
  assign feat[3] = in_data.feature_d;

  always_ff @(posedge clk) begin
    if (load) begin
      if (int'(in_data.coeff_index) < FEATURES) begin
        mean_c[in_data.coeff_index[FW-1:0]] <= in_data.coeff_value;
      end else if (int'(in_data.coeff_index) < 2 * FEATURES) begin
        isd_c[FW'(in_data.coeff_index - 6'(FEATURES))] <= in_data.coeff_value;
      end
      if (int'(in_data.coeff_index) == OFS_B2) begin
        bias2 <= in_data.coeff_value;
      end
    end
    if (accept && in_data.command == mes_pkg::CMD_SCORE) begin
      for (int f = 0; f < FEATURES; f++) raw[f] <= feat[f];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mes_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mes_pkg::ST_IDLE:
        if (accept && in_data.command == mes_pkg::CMD_SCORE) state_next = mes_pkg::ST_NORM;
      mes_pkg::ST_NORM:
        if (ph == 2'd2 && int'(fi) == FEATURES - 1) state_next = mes_pkg::ST_HID;
      mes_pkg::ST_HID:
        if (int'(fi) == FEATURES - 1) state_next = mes_pkg::ST_OUT;
      mes_pkg::ST_OUT:
        if (int'(hi) == HIDDEN - 1) state_next = mes_pkg::ST_SIG;
      mes_pkg::ST_SIG:
        state_next = mes_pkg::ST_DONE;
      mes_pkg::ST_DONE:
        if (!out_stall) state_next = mes_pkg::ST_IDLE;
      default: state_next = mes_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    start = (state == mes_pkg::ST_NORM) && ph == 2'd2 && int'(fi) == FEATURES - 1;
    lstep = (state == mes_pkg::ST_HID);
    mstep = (state == mes_pkg::ST_OUT);
  end

  assign diff = (29'(raw[fi]) <<< 4) - 29'(mean_r);
  assign nprod = diff * isd_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      fi <= '0;
      hi <= '0;
      ph <= '0;
    end else begin
      unique case (state)
        mes_pkg::ST_IDLE: begin
          fi <= '0;
          hi <= '0;
          ph <= '0;
        end
        mes_pkg::ST_NORM: begin
          if (ph == 2'd2) begin
            ph <= '0;
            fi <= (int'(fi) == FEATURES - 1) ? '0 : fi + 1'b1;
          end else begin
            ph <= ph + 2'd1;
          end
        end
        mes_pkg::ST_HID: fi <= fi + 1'b1;
        mes_pkg::ST_OUT: hi <= hi + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == mes_pkg::ST_NORM) begin
      if (ph == 2'd0) mean_r <= mean_c[fi];
      if (ph == 2'd1) isd_r <= isd_c[fi];
      if (ph == 2'd2) xr[fi] <= mes_pkg::to_q12(64'(nprod));
    end
  end

  for (genvar j = 0; j < HIDDEN; j++) begin : g_lane
    mes_lane #(
      .FEATURES(FEATURES),
      .HIDDEN  (HIDDEN),
      .LANE    (j)
    ) u_lane (
      .clk  (clk),
      .load (load),
      .index(in_data.coeff_index),
      .value(in_data.coeff_value),
      .start(start),
      .step (lstep),
      .sel  (fi),
      .x    (xr[fi]),
      .h    (hv[j]),
      .w2   (w2v[j])
    );
  end

  mes_merge u_merge (
    .clk  (clk),
    .start(start),
    .step (mstep),
    .bias (bias2),
    .h    (hv[hi]),
    .w    (w2v[hi]),
    .logit(logit)
  );

  assign lg = logit;
  assign a = lg[23] ? 16'(-32'(lg)) : lg[15:0];
  assign lo = mes_pkg::sig_tab({1'b0, a[14:11]});
  assign hi_t = mes_pkg::sig_tab(5'({1'b0, a[14:11]} + 5'd1));
  assign dl = 19'(hi_t) - 19'(lo);
  assign ip = dl * $signed({1'b0, 11'(a[10:0])}) + 31'sd1024;

  always_comb begin
    if ((lg >= 24'sd32768) || (lg <= -24'sd32768)) begin
      pos = mes_pkg::sig_tab(5'd16);
    end else begin
      pos = lo + 17'(ip >>> 11);
    end
  end

  always_ff @(posedge clk) begin
    if (state == mes_pkg::ST_SIG) begin
      out_data.logit <= lg;
      out_data.score <= lg[23] ? 16'(17'd65536 - pos) : pos[15:0];
    end
  end

  a_stall_idle: assert property (@(posedge clk) disable iff (rst)
    (state == mes_pkg::ST_IDLE) |-> !in_stall)
    else $error("stall while idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !accept)
    else $error("accept while result pending");

endmodule

FILE: sv/mes_lane.sv
// ----------------------------------------------------------------------------
// mes_lane: one hidden-neuron lane
// Holds the coefficients of one hidden unit and accumulates bias and
// feature products for it.
// ----------------------------------------------------------------------------
module mes_lane #(
  parameter int FEATURES = mes_pkg::FEATURES_DEF,
  parameter int HIDDEN   = mes_pkg::HIDDEN_DEF,
  parameter int LANE     = 0
) (
  input  logic               clk,
  input  logic               load,
  input  logic [5:0]         index,
  input  logic signed [23:0] value,
  input  logic               start,
  input  logic               step,
  input  logic [$clog2(FEATURES > 1 ? FEATURES : 2)-1:0] sel,
  input  logic signed [23:0] x,
  output logic signed [23:0] h,
  output logic signed [23:0] w2
);

  localparam int OFS_W1 = 2 * FEATURES;
  localparam int OFS_B1 = OFS_W1 + FEATURES * HIDDEN;
  localparam int OFS_W2 = OFS_B1 + HIDDEN;

  logic signed [23:0] w1 [FEATURES];
  logic signed [23:0] b1;
  logic signed [23:0] w2r;
  logic signed [55:0] acc;
  logic signed [47:0] prod;

  assign prod = x * w1[sel];
  assign h = mes_pkg::to_q12(64'(acc));
  assign w2 = w2r;

  always_ff @(posedge clk) begin
    if (load) begin
      for (int f = 0; f < FEATURES; f++) begin
        if (int'(index) == OFS_W1 + f * HIDDEN + LANE) w1[f] <= value;
      end
      if (int'(index) == OFS_B1 + LANE) b1 <= value;
      if (int'(index) == OFS_W2 + LANE) w2r <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= 56'(b1) <<< 12;
    end else if (step) begin
      acc <= acc + 56'(prod);
    end
  end

endmodule

FILE: sv/mes_merge.sv
// ----------------------------------------------------------------------------
// mes_merge: output neuron merge
// Sums the output bias and positive lane outputs times output weights, one lane per cycle.
// ----------------------------------------------------------------------------
module mes_merge (
  input  logic               clk,
  input  logic               start,
  input  logic               step,
  input  logic signed [23:0] bias,
  input  logic signed [23:0] h,
  input  logic signed [23:0] w,
  output logic signed [23:0] logit
);

  logic signed [55:0] acc;
  logic signed [47:0] prod;

  assign prod = (h > 24'sd0) ? h * w : 48'sd0;
  assign logit = mes_pkg::to_q12(64'(acc));

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= 56'(bias) <<< 12;
    end else if (step) begin
      acc <= acc + 56'(prod);
    end
  end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for mlp_event_scorer_unit
// Loads coefficient sets, scores directed and random events, and compares
// each result with a fixed-point perceptron predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCOEF   = 57;
  localparam int OFS_ISD = 4;
  localparam int OFS_W1  = 8;
  localparam int OFS_B1  = 40;
  localparam int OFS_W2  = 48;
  localparam int OFS_B2  = 56;
  localparam int WATCHDOG = 20000;

  typedef struct {
    mes_pkg::in_t  txn;
    bit            check_fixed;
    mes_pkg::out_t fixed;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  mes_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mes_pkg::out_t out_data;

  mlp_event_scorer_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  longint coeff_model[NCOEF];
  mes_pkg::out_t scores_pending[$];
  mes_pkg::out_t fixed_pending[$];
  bit fixed_flag[$];
  int mismatches = 0;
  int idle_cycles = 0;
  row_t rows[$];

  function automatic longint rshift_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint round_q12(longint v);
    return clamp24(rshift_floor(v + 2048, 12));
  endfunction

  function automatic longint sig_point(int k);
    longint t[17] = '{32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615,
                      64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500,
                      65514};
    return t[k];
  endfunction

  function automatic mes_pkg::out_t score_event(mes_pkg::in_t t);
    longint x[4];
    longint raw[4];
    longint acc, h, a, p, lo, hi;
    int i, j;
    mes_pkg::out_t r;
    raw[0] = t.feature_a; raw[1] = t.feature_b;
    raw[2] = t.feature_c; raw[3] = t.feature_d;
    for (i = 0; i < 4; i++)
      x[i] = round_q12((raw[i] * 16 - coeff_model[i]) * coeff_model[OFS_ISD + i]);
    acc = coeff_model[OFS_B2] * 4096;
    for (j = 0; j < 8; j++) begin
      h = coeff_model[OFS_B1 + j] * 4096;
      for (i = 0; i < 4; i++) h += x[i] * coeff_model[OFS_W1 + i * 8 + j];
      h = round_q12(h);
      if (h > 0) acc += h * coeff_model[OFS_W2 + j];
    end
    acc = round_q12(acc);
    a = acc < 0 ? -acc : acc;
    if (a >= 32768) p = sig_point(16);
    else begin
      lo = sig_point(int'(a >> 11));
      hi = sig_point(int'(a >> 11) + 1);
      p = lo + (((hi - lo) * (a & 2047) + 1024) >>> 11);
    end
    if (acc < 0) p = 65536 - p;
    r.logit = acc[23:0];
    r.score = p[15:0];
    return r;
  endfunction

  function automatic mes_pkg::in_t load_txn(int idx, longint v);
    mes_pkg::in_t t;
    t = '0;
    t.command = mes_pkg::CMD_LOAD;
    t.coeff_index = idx[5:0];
    t.coeff_value = v[23:0];
    return t;
  endfunction

  function automatic mes_pkg::in_t score_txn(longint a, longint b, longint c, longint d);
    mes_pkg::in_t t;
    t = '0;
    t.command = mes_pkg::CMD_SCORE;
    t.coeff_index = 6'($urandom);
    t.coeff_value = 24'($urandom);
    t.feature_a = a[23:0]; t.feature_b = b[23:0];
    t.feature_c = c[23:0]; t.feature_d = d[23:0];
    return t;
  endfunction

  function automatic longint rand_coeff();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $signed(24'($urandom));
    if (sel == 1) return $urandom_range(0, 1) ? 8388607 : -8388608;
    return longint'($urandom_range(0, 16384)) - 8192;
  endfunction

  function automatic longint rand_feature();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $signed(24'($urandom));
    if (sel == 1) return $urandom_range(0, 1) ? 8388607 : -8388608;
    return longint'($urandom_range(0, 4096)) - 2048;
  endfunction

  task automatic send(mes_pkg::in_t t, bit has_fixed, mes_pkg::out_t fx);
    in_data  <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (t.command == mes_pkg::CMD_LOAD) begin
      if (t.coeff_index < NCOEF) coeff_model[t.coeff_index] = t.coeff_value;
    end else begin
      scores_pending.push_back(score_event(t));
      fixed_flag.push_back(has_fixed);
      fixed_pending.push_back(fx);
    end
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) out_stall <= ($urandom_range(0, 7) < 3) && ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    mes_pkg::out_t exp_r;
    mes_pkg::out_t fx;
    bit ff;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (scores_pending.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data);
        end else begin
          exp_r = scores_pending.pop_front();
          ff = fixed_flag.pop_front();
          fx = fixed_pending.pop_front();
          if (ff && fx != exp_r) exp_r = fx;
          if (out_data.logit !== exp_r.logit || out_data.score !== exp_r.score) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp logit %h score %h, got logit %h score %h",
                       exp_r.logit, exp_r.score, out_data.logit, out_data.score);
          end
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic load_all(bit extreme);
    int i;
    for (i = 0; i < NCOEF; i++)
      send(load_txn(i, extreme ? (($urandom_range(0, 1)) ? 8388607 : -8388608)
                               : rand_coeff()), 1'b0, '0);
  endtask

  initial begin
    row_t r;
    mes_pkg::out_t fx;
    int i, n;
    for (i = 0; i < NCOEF; i++) coeff_model[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero all coefficients: logit 0, score one half
    for (i = 0; i < NCOEF; i++) send(load_txn(i, 0), 1'b0, '0);
    fx.logit = 24'sd0; fx.score = 16'd32768;
    rows.push_back('{score_txn(8388607, -8388608, 0, 1), 1'b1, fx});
    // out-of-range load addresses are dropped
    rows.push_back('{load_txn(57, 8388607), 1'b0, '0});
    rows.push_back('{load_txn(63, -8388608), 1'b0, '0});
    // output bias alone: large positive and negative logits
    rows.push_back('{load_txn(OFS_B2, 8388607), 1'b0, '0});
    fx.logit = 24'sh7fffff; fx.score = 16'd65514;
    rows.push_back('{score_txn(0, 0, 0, 0), 1'b1, fx});
    rows.push_back('{load_txn(OFS_B2, -8388608), 1'b0, '0});
    fx.logit = 24'sh800000; fx.score = 16'd22;
    rows.push_back('{score_txn(-8388608, 8388607, -1, 0), 1'b1, fx});
    rows.push_back('{load_txn(OFS_B2, 4096), 1'b0, '0});
    rows.push_back('{score_txn(0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{load_txn(OFS_B2, -2048), 1'b0, '0});
    rows.push_back('{score_txn(0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{load_txn(OFS_B2, 32768), 1'b0, '0});
    rows.push_back('{score_txn(0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{load_txn(OFS_B2, 0), 1'b0, '0});
    foreach (rows[k]) begin
      r = rows[k];
      send(r.txn, r.check_fixed, r.fixed);
    end

    load_all(1'b1);
    repeat (4)
      send(score_txn(rand_feature(), rand_feature(), rand_feature(), rand_feature()),
           1'b0, '0);

    n = 0;
    while (n < 520) begin
      if ($urandom_range(0, 7) == 0) begin
        load_all(1'b0);
        n += NCOEF;
      end else if ($urandom_range(0, 5) == 0) begin
        send(load_txn($urandom_range(0, 63), rand_coeff()), 1'b0, '0);
        n++;
      end else begin
        send(score_txn(rand_feature(), rand_feature(), rand_feature(), rand_feature()),
             1'b0, '0);
        n++;
      end
    end
    in_valid <= 1'b0;

    while (scores_pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
